// File: hw/rtl/dijk_pkg.sv
// ----------------------------------------------------------------------------
// Dense Dijkstra package
// Shared widths, codes and interface structs for the shortest path engine.
// ----------------------------------------------------------------------------
package dijk_pkg;

  localparam int unsigned NodeMax = 64;
  localparam int unsigned IdxW    = $clog2(NodeMax);
  localparam int unsigned CntW    = $clog2(NodeMax + 1);
  localparam int unsigned WAddrW  = 2 * IdxW;
  localparam int unsigned DistW   = 40;
  localparam int unsigned WeightW = 30;
  localparam int unsigned ActW    = 2;

  localparam logic [DistW-1:0] DistOnes = {DistW{1'b1}};

  typedef enum logic [ActW-1:0] {
    ActWeight = 2'd0,
    ActDist   = 2'd1,
    ActRun    = 2'd2
  } action_e;

  typedef enum logic {
    OpScan  = 1'b0,
    OpRelax = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e             op;
    logic [DistW-1:0]    base;
    logic [DistW-1:0]    cand;
    logic [WeightW-1:0]  weight;
  } alu_req_t;

  typedef struct packed {
    logic             lt;
    logic [DistW-1:0] sum;
  } alu_rsp_t;

  typedef struct packed {
    logic               w_we;
    logic [WAddrW-1:0]  w_waddr;
    logic [WeightW-1:0] w_wdata;
    logic [WAddrW-1:0]  w_raddr;
    logic               d_we;
    logic [IdxW-1:0]    d_waddr;
    logic [DistW-1:0]   d_wdata;
    logic [IdxW-1:0]    d_raddr;
  } mem_req_t;

endpackage

// File: hw/rtl/dijk_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dijk_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/dijk_alu.sv
// ----------------------------------------------------------------------------
// Shared compare and add unit
// Saturating distance plus weight, and one less-than compare shared by the
// minimum search and the relaxation step.
// ----------------------------------------------------------------------------
module dijk_alu (
  input  dijk_pkg::alu_req_t req_i,
  output dijk_pkg::alu_rsp_t rsp_o
);

  logic [dijk_pkg::DistW:0]   sum_wide;
  logic [dijk_pkg::DistW-1:0] sum_sat;
  logic [dijk_pkg::DistW-1:0] lhs;
  logic [dijk_pkg::DistW-1:0] rhs;

  assign sum_wide = {1'b0, req_i.base}
                  + {{(dijk_pkg::DistW - dijk_pkg::WeightW + 1){1'b0}}, req_i.weight};
  assign sum_sat  = sum_wide[dijk_pkg::DistW] ? dijk_pkg::DistOnes
                                              : sum_wide[dijk_pkg::DistW-1:0];

  always_comb begin
    if (req_i.op == dijk_pkg::OpRelax) begin
      lhs = sum_sat;
      rhs = req_i.cand;
    end else begin
      lhs = req_i.cand;
      rhs = req_i.base;
    end
  end

  assign rsp_o.lt  = lhs < rhs;
  assign rsp_o.sum = sum_sat;

endmodule

// File: hw/rtl/dijk_seq.sv
// ----------------------------------------------------------------------------
// Dijkstra sequencer
// Handles load requests, walks the minimum search and relaxation passes over
// the memories, and emits one result per node.
// ----------------------------------------------------------------------------
module dijk_seq (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [dijk_pkg::ActW-1:0]            action_i,
  input  logic [dijk_pkg::IdxW-1:0]            row_node_i,
  input  logic [dijk_pkg::IdxW-1:0]            col_node_i,
  input  logic [dijk_pkg::DistW-1:0]           value_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dijk_pkg::CntW-1:0]            cfg_node_count_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [dijk_pkg::IdxW-1:0]            node_index_o,
  output logic [dijk_pkg::DistW-1:0]           distance_o,
  output logic                                 last_result_o,
  output dijk_pkg::mem_req_t                   mem_o,
  input  logic [dijk_pkg::WeightW-1:0]         w_rdata_i,
  input  logic [dijk_pkg::DistW-1:0]           d_rdata_i,
  output dijk_pkg::alu_req_t                   alu_req_o,
  input  dijk_pkg::alu_rsp_t                   alu_rsp_i
);

  typedef enum logic [5:0] {
    StIdle    = 6'b000001,
    StScan    = 6'b000010,
    StRelax   = 6'b000100,
    StEmitRd  = 6'b001000,
    StEmitLd  = 6'b010000,
    StEmitOut = 6'b100000
  } state_e;

  state_e                              state_q, state_d;
  logic [dijk_pkg::CntW-1:0]           ncount_q, ncount_d;
  logic [dijk_pkg::CntW-1:0]           cnt_q, cnt_d;
  logic [dijk_pkg::CntW-1:0]           idx_q, idx_d;
  logic                                pv_q, pv_d;
  logic                                found_q, found_d;
  logic [dijk_pkg::NodeMax-1:0]        settled_q, settled_d;
  logic                                out_valid_q, out_valid_d;
  logic [dijk_pkg::IdxW-1:0]           pidx_q, pidx_d;
  logic [dijk_pkg::IdxW-1:0]           m_q, m_d;
  logic [dijk_pkg::DistW-1:0]          best_q, best_d;
  logic [dijk_pkg::IdxW-1:0]           out_idx_q, out_idx_d;
  logic [dijk_pkg::DistW-1:0]          out_dist_q, out_dist_d;
  logic                                out_last_q, out_last_d;

  logic                                in_fire;
  dijk_pkg::action_e                   act;
  logic                                issue;
  logic                                hit;
  logic [dijk_pkg::CntW-1:0]           cnt_use;

  assign in_ready_o    = (state_q == StIdle);
  assign cfg_ready_o   = (state_q == StIdle);
  assign in_fire       = in_valid_i && in_ready_o;
  assign act           = dijk_pkg::action_e'(action_i);
  assign issue         = (idx_q != cnt_q);
  assign hit           = pv_q && !settled_q[pidx_q] && alu_rsp_i.lt;

  assign out_valid_o   = out_valid_q;
  assign node_index_o  = out_idx_q;
  assign distance_o    = out_dist_q;
  assign last_result_o = out_last_q;

  always_comb begin
    if (ncount_q == '0) begin
      cnt_use = dijk_pkg::CntW'(1);
    end else if (ncount_q > dijk_pkg::CntW'(dijk_pkg::NodeMax)) begin
      cnt_use = dijk_pkg::CntW'(dijk_pkg::NodeMax);
    end else begin
      cnt_use = ncount_q;
    end
  end

  always_comb begin
    alu_req_o.op     = (state_q == StRelax) ? dijk_pkg::OpRelax : dijk_pkg::OpScan;
    alu_req_o.base   = best_q;
    alu_req_o.cand   = d_rdata_i;
    alu_req_o.weight = w_rdata_i;
  end

  always_comb begin
    mem_o.w_we    = in_fire && (act == dijk_pkg::ActWeight);
    mem_o.w_waddr = {row_node_i, col_node_i};
    mem_o.w_wdata = value_i[dijk_pkg::WeightW-1:0];
    mem_o.w_raddr = {m_q, idx_q[dijk_pkg::IdxW-1:0]};
    mem_o.d_raddr = idx_q[dijk_pkg::IdxW-1:0];
    if (state_q == StRelax) begin
      mem_o.d_we    = hit;
      mem_o.d_waddr = pidx_q;
      mem_o.d_wdata = alu_rsp_i.sum;
    end else begin
      mem_o.d_we    = in_fire && (act == dijk_pkg::ActDist);
      mem_o.d_waddr = row_node_i;
      mem_o.d_wdata = value_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    ncount_d    = ncount_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    pv_d        = 1'b0;
    found_d     = found_q;
    settled_d   = settled_q;
    out_valid_d = out_valid_q;
    pidx_d      = idx_q[dijk_pkg::IdxW-1:0];
    m_d         = m_q;
    best_d      = best_q;
    out_idx_d   = out_idx_q;
    out_dist_d  = out_dist_q;
    out_last_d  = out_last_q;

    if (cfg_valid_i && cfg_ready_o) begin
      ncount_d = cfg_node_count_i;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire && (act == dijk_pkg::ActRun)) begin
          settled_d = '0;
          cnt_d     = cnt_use;
          idx_d     = '0;
          best_d    = dijk_pkg::DistOnes;
          found_d   = 1'b0;
          state_d   = StScan;
        end
      end
      StScan: begin
        if (issue) begin
          pv_d  = 1'b1;
          idx_d = idx_q + dijk_pkg::CntW'(1);
        end
        if (hit) begin
          best_d  = d_rdata_i;
          m_d     = pidx_q;
          found_d = 1'b1;
        end
        if (!issue && !pv_q) begin
          idx_d = '0;
          if (found_q) begin
            settled_d[m_q] = 1'b1;
            state_d        = StRelax;
          end else begin
            state_d = StEmitRd;
          end
        end
      end
      StRelax: begin
        if (issue) begin
          pv_d  = 1'b1;
          idx_d = idx_q + dijk_pkg::CntW'(1);
        end
        if (!issue && !pv_q) begin
          idx_d   = '0;
          best_d  = dijk_pkg::DistOnes;
          found_d = 1'b0;
          state_d = StScan;
        end
      end
      StEmitRd: begin
        state_d = StEmitLd;
      end
      StEmitLd: begin
        out_dist_d  = d_rdata_i;
        out_idx_d   = idx_q[dijk_pkg::IdxW-1:0];
        out_last_d  = ((idx_q + dijk_pkg::CntW'(1)) == cnt_q);
        out_valid_d = 1'b1;
        state_d     = StEmitOut;
      end
      StEmitOut: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = StIdle;
          end else begin
            idx_d   = idx_q + dijk_pkg::CntW'(1);
            state_d = StEmitRd;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ncount_q    <= dijk_pkg::CntW'(dijk_pkg::NodeMax);
      cnt_q       <= dijk_pkg::CntW'(dijk_pkg::NodeMax);
      idx_q       <= '0;
      pv_q        <= 1'b0;
      found_q     <= 1'b0;
      settled_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ncount_q    <= ncount_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      pv_q        <= pv_d;
      found_q     <= found_d;
      settled_q   <= settled_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q     <= pidx_d;
    m_q        <= m_d;
    best_q     <= best_d;
    out_idx_q  <= out_idx_d;
    out_dist_q <= out_dist_d;
    out_last_q <= out_last_d;
  end

endmodule

// File: hw/rtl/dense_dijkstra_shortest_paths.sv
// A run covers the N nodes in use with up to N settling rounds and at most
// N + 1 search passes, and an output stall can hold it. Each pass reads the
// single read port of the distance RAM, which feeds the shared compare and
// add unit. Throughput: one request at a time; not ready in a run.
// Reset: asynchronous, active low; node count returns to 64, RAMs keep data.
// ----------------------------------------------------------------------------
// Dense Dijkstra shortest paths
// Multi-source Dijkstra over a stored dense weight matrix, one node at a time
// through a shared compare and add unit.
// ----------------------------------------------------------------------------
module dense_dijkstra_shortest_paths (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [dijk_pkg::ActW-1:0]            action_i,
  input  logic [dijk_pkg::IdxW-1:0]            row_node_i,
  input  logic [dijk_pkg::IdxW-1:0]            col_node_i,
  input  logic [dijk_pkg::DistW-1:0]           value_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dijk_pkg::CntW-1:0]            cfg_node_count_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [dijk_pkg::IdxW-1:0]            node_index_o,
  output logic [dijk_pkg::DistW-1:0]           distance_o,
  output logic                                 last_result_o
);

  dijk_pkg::mem_req_t           mem;
  dijk_pkg::alu_req_t           alu_req;
  dijk_pkg::alu_rsp_t           alu_rsp;
  logic [dijk_pkg::WeightW-1:0] w_rdata;
  logic [dijk_pkg::DistW-1:0]   d_rdata;

  dijk_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .row_node_i       (row_node_i),
    .col_node_i       (col_node_i),
    .value_i          (value_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_node_count_i (cfg_node_count_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .node_index_o     (node_index_o),
    .distance_o       (distance_o),
    .last_result_o    (last_result_o),
    .mem_o            (mem),
    .w_rdata_i        (w_rdata),
    .d_rdata_i        (d_rdata),
    .alu_req_o        (alu_req),
    .alu_rsp_i        (alu_rsp)
  );

  dijk_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  dijk_ram #(
    .Depth (dijk_pkg::NodeMax * dijk_pkg::NodeMax),
    .Width (dijk_pkg::WeightW)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (mem.w_we),
    .waddr_i (mem.w_waddr),
    .wdata_i (mem.w_wdata),
    .raddr_i (mem.w_raddr),
    .rdata_o (w_rdata)
  );

  dijk_ram #(
    .Depth (dijk_pkg::NodeMax),
    .Width (dijk_pkg::DistW)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (mem.d_we),
    .waddr_i (mem.d_waddr),
    .wdata_i (mem.d_wdata),
    .raddr_i (mem.d_raddr),
    .rdata_o (d_rdata)
  );

endmodule

// File: hw/rtl/dijk_checker.sv
// ----------------------------------------------------------------------------
// Dijkstra port checker
// Checks result stability under stall and the handshake ordering between the input and result channels.
// ----------------------------------------------------------------------------
module dijk_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic [dijk_pkg::ActW-1:0]      action_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [dijk_pkg::DistW-1:0]     distance_o,
  input logic                           last_result_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o))
    else $error("Result request changed while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("Input ready while a result is pending.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == dijk_pkg::ActRun) |=> !in_ready_o)
    else $error("Ready right after a run request.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o)
    else $error("Result valid right after a taken result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_result_o |=> in_ready_o)
    else $error("Not ready after the last result.");

endmodule

bind dense_dijkstra_shortest_paths dijk_checker u_dijk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .action_i      (action_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .distance_o    (distance_o),
  .last_result_o (last_result_o)
);
